// File: sv/sirad_pkg.sv
package sirad_pkg;

  localparam int MAX_RADIX = 16;
  localparam int DATA_W    = 32;
  localparam int CHAR_W    = 8;
  localparam int DIG_W     = $clog2(MAX_RADIX);
  localparam int LEN_W     = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int NDIG      = DATA_W;
  localparam int NDIG_W    = $clog2(NDIG);
  localparam int CNT_W     = NDIG_W + 1;
  localparam int STEP_W    = $clog2(DATA_W);
  localparam int GLYPHS    = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RADIX_LEN = 2'd0;
  localparam cfg_idx_t CFG_ALPHA_LO  = 2'd1;
  localparam cfg_idx_t CFG_ALPHA_HI  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [LEN_W-1:0] RST_RADIX_LEN = 5'd10;
  localparam logic [CFG_W-1:0] RST_ALPHA_LO  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0] RST_ALPHA_HI  = 64'h0000_0000_0000_3938;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DATA_W-1:0]   dividend;
    logic [LEN_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DATA_W-1:0]   quot;
    logic [DIG_W-1:0]    rem;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] glyph_at(input logic [CFG_W-1:0] lo,
                                                 input logic [CFG_W-1:0] hi,
                                                 input logic [DIG_W-1:0] idx);
    logic [2*CFG_W-1:0] all;
    all = {hi, lo};
    return all[idx*CHAR_W +: CHAR_W];
  endfunction

endpackage

// File: sv/sirad_if.sv
interface sirad_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sirad_pkg::DATA_W-1:0]  value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface sirad_out_if;
  logic                          valid;
  logic                          ready;
  logic [sirad_pkg::CHAR_W-1:0]  out_char;
  logic                          last_char;

  modport source(output valid, output out_char, output last_char, input ready);
  modport sink(input valid, input out_char, input last_char, output ready);
endinterface

// File: sv/sirad_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module sirad_div (
  input  logic                clk,
  input  logic                rst_n,
  input  sirad_pkg::div_req_t req,
  output sirad_pkg::div_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [sirad_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [sirad_pkg::DATA_W-1:0]   q_r, q_nxt;
  logic [sirad_pkg::DIG_W-1:0]    rem_r, rem_nxt;
  logic [sirad_pkg::LEN_W-1:0]    dvs_r, dvs_nxt;
  logic [sirad_pkg::LEN_W-1:0]    trial;
  logic                           fits;

  always_comb begin
    trial    = {rem_r, q_r[sirad_pkg::DATA_W-1]};
    fits     = (trial >= dvs_r);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[sirad_pkg::DATA_W-2:0], fits};
      rem_nxt = fits ? sirad_pkg::DIG_W'(trial - dvs_r) : trial[sirad_pkg::DIG_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == sirad_pkg::STEP_W'(sirad_pkg::DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

// File: sv/signed_int_to_radix_digits_core.sv
// Flow: accept, then a check of each alphabet glyph in use, then one bit-serial division
//   per digit, then the characters are emitted; the output register stalls on out_ch.ready.
// Throughput: one item at a time; a new value is taken only when the sequencer is idle.
//   The divider sets the pace.
// Reset: synchronous active-low rst_n; registers return to radix 10, alphabet "0123456789",
//   sequencer idle and the output register empty.
module signed_int_to_radix_digits_core (
  input  logic                            clk,
  input  logic                            rst_n,
  sirad_in_if.sink                        in_ch,
  sirad_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  sirad_pkg::cfg_idx_t             cfg_idx,
  input  logic [sirad_pkg::CFG_W-1:0]     cfg_data
);

  // Configuration registers
  logic [sirad_pkg::LEN_W-1:0]  radix_len_r;
  logic [sirad_pkg::CFG_W-1:0]  alpha_lo_r;
  logic [sirad_pkg::CFG_W-1:0]  alpha_hi_r;

  // Sequencer state
  sirad_pkg::state_t             state_r, state_nxt;
  logic [sirad_pkg::DATA_W-1:0]  mag_r, mag_nxt;
  logic                          neg_r, neg_nxt;
  logic [sirad_pkg::DIG_W-1:0]   chk_i_r, chk_i_nxt;
  logic [sirad_pkg::CNT_W-1:0]   nd_r, nd_nxt;

  // Digit stack, least significant digit at entry 0
  logic [sirad_pkg::DIG_W-1:0]   digits_r [sirad_pkg::NDIG];
  logic                          dig_we;

  // Output register
  logic                          oval_r, oval_nxt;
  logic [sirad_pkg::CHAR_W-1:0]  ochar_r, ochar_nxt;
  logic                          olast_r, olast_nxt;
  logic                          out_load;

  sirad_pkg::div_req_t           div_req;
  sirad_pkg::div_rsp_t           div_rsp;

  logic                          accept;
  logic                          len_ok;
  logic [sirad_pkg::DIG_W-1:0]   len_m1;
  logic [sirad_pkg::CHAR_W-1:0]  chk_glyph;
  logic                          chk_hit;
  logic [sirad_pkg::CNT_W-1:0]   nd_inc;
  logic [sirad_pkg::CNT_W-1:0]   rd_idx;
  logic [sirad_pkg::DATA_W-1:0]  raw;

  sirad_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_ch.ready = (state_r == sirad_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign raw         = in_ch.value;

  // Radix must lie in 2..MAX_RADIX
  assign len_ok = (radix_len_r >= sirad_pkg::LEN_W'(2)) &&
                  (radix_len_r <= sirad_pkg::LEN_W'(sirad_pkg::MAX_RADIX));
  assign len_m1 = sirad_pkg::DIG_W'(radix_len_r - 1'b1);

  // One glyph per cycle: sign characters, or a duplicate among later glyphs in use
  always_comb begin
    chk_glyph = sirad_pkg::glyph_at(alpha_lo_r, alpha_hi_r, chk_i_r);
    chk_hit   = (chk_glyph == sirad_pkg::CHAR_PLUS) || (chk_glyph == sirad_pkg::CHAR_MINUS);
    for (int j = 0; j < sirad_pkg::GLYPHS; j++) begin
      if ((sirad_pkg::LEN_W'(j) > {1'b0, chk_i_r}) && (sirad_pkg::LEN_W'(j) < radix_len_r) &&
          (sirad_pkg::glyph_at(alpha_lo_r, alpha_hi_r, sirad_pkg::DIG_W'(j)) == chk_glyph)) begin
        chk_hit = 1'b1;
      end
    end
  end

  assign out_load = !oval_r || out_ch.ready;
  assign nd_inc   = nd_r + 1'b1;
  assign rd_idx   = nd_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    chk_i_nxt = chk_i_r;
    nd_nxt    = nd_r;
    dig_we    = 1'b0;
    oval_nxt  = oval_r && !out_ch.ready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    div_req.start    = 1'b0;
    div_req.dividend = mag_r;
    div_req.divisor  = radix_len_r;

    unique case (state_r)
      sirad_pkg::ST_IDLE: begin
        if (accept) begin
          neg_nxt   = raw[sirad_pkg::DATA_W-1];
          mag_nxt   = raw[sirad_pkg::DATA_W-1] ? (sirad_pkg::DATA_W'(0) - raw) : raw;
          chk_i_nxt = '0;
          nd_nxt    = '0;
          // A bad radix drops the item with no output
          state_nxt = len_ok ? sirad_pkg::ST_CHECK : sirad_pkg::ST_IDLE;
        end
      end
      sirad_pkg::ST_CHECK: begin
        if (chk_hit) begin
          state_nxt = sirad_pkg::ST_IDLE;
        end else if (chk_i_r == len_m1) begin
          state_nxt = sirad_pkg::ST_DIV;
        end else begin
          chk_i_nxt = chk_i_r + 1'b1;
        end
      end
      sirad_pkg::ST_DIV: begin
        div_req.start = 1'b1;
        state_nxt     = sirad_pkg::ST_DIV_WAIT;
      end
      sirad_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          dig_we  = 1'b1;
          nd_nxt  = nd_inc;
          mag_nxt = div_rsp.quot;
          if ((div_rsp.quot == '0) || (nd_inc == sirad_pkg::CNT_W'(sirad_pkg::NDIG))) begin
            state_nxt = neg_r ? sirad_pkg::ST_SIGN : sirad_pkg::ST_EMIT;
          end else begin
            state_nxt = sirad_pkg::ST_DIV;
          end
        end
      end
      sirad_pkg::ST_SIGN: begin
        if (out_load) begin
          oval_nxt  = 1'b1;
          ochar_nxt = sirad_pkg::CHAR_MINUS;
          olast_nxt = 1'b0;
          state_nxt = sirad_pkg::ST_EMIT;
        end
      end
      sirad_pkg::ST_EMIT: begin
        // Pop digits most significant first
        if (out_load) begin
          oval_nxt  = 1'b1;
          ochar_nxt = sirad_pkg::glyph_at(alpha_lo_r, alpha_hi_r,
                                          digits_r[rd_idx[sirad_pkg::NDIG_W-1:0]]);
          olast_nxt = (nd_r == sirad_pkg::CNT_W'(1));
          nd_nxt    = rd_idx;
          if (nd_r == sirad_pkg::CNT_W'(1)) begin
            state_nxt = sirad_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sirad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sirad_pkg::ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    chk_i_r <= chk_i_nxt;
    nd_r    <= nd_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      digits_r[nd_r[sirad_pkg::NDIG_W-1:0]] <= div_rsp.rem;
    end
  end

  // Config writes; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_len_r <= sirad_pkg::RST_RADIX_LEN;
      alpha_lo_r  <= sirad_pkg::RST_ALPHA_LO;
      alpha_hi_r  <= sirad_pkg::RST_ALPHA_HI;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sirad_pkg::CFG_RADIX_LEN: radix_len_r <= cfg_data[sirad_pkg::LEN_W-1:0];
        sirad_pkg::CFG_ALPHA_LO:  alpha_lo_r  <= cfg_data;
        sirad_pkg::CFG_ALPHA_HI:  alpha_hi_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid     = oval_r;
  assign out_ch.out_char  = ochar_r;
  assign out_ch.last_char = olast_r;

endmodule
